### design/rpa_pkg.sv
// types and constants shared by the region page allocator
package rpa_pkg;

  localparam int AGE_W = 16;

  localparam logic [2:0] ST_ALLOC    = 3'd0;
  localparam logic [2:0] ST_FALLBACK = 3'd1;
  localparam logic [2:0] ST_FREED    = 3'd2;
  localparam logic [2:0] ST_RELEASED = 3'd3;
  localparam logic [2:0] ST_REJECT   = 3'd4;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef struct packed {
    logic       func;
    logic [1:0] domain;
    logic       zero_fill;
    logic [3:0] region;
    logic [3:0] page_offset;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] out_region;
    logic [3:0] out_offset;
    logic       clear_page;
    logic       new_region;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PICK,
    S_FREE,
    S_FIN
  } state_t;

endpackage

### design/rpa_stack_ram.sv
// free-page stack storage, one write port and one registered read port
module rpa_stack_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/region_page_allocator.sv
// Region page allocator.
// Input channel in_valid/in_stall/in_data carries one request word: allocate
// a page for a domain, or free a page of a region slot. Each request gives
// exactly one result word on out_valid/out_stall/out_data.
// One request is worked on at a time; in_stall is high from acceptance until
// the result is loaded into the output register. A result waiting there does
// not hold off the next request.
// Allocate: accept, then scan the slot table one slot per cycle (free slot,
// open regions, newest open region), then pick and update, then the stack
// memory read. Free: accept, then an update step with one memory write for
// the push.
// Pages come from a per-region LIFO stack in a synchronous memory of
// REGIONS * 2^REGION_ORDER entries, else from the region's bump index.
// Reset (rst_n low, synchronous) clears slot valid bits, counters, domain
// caches and the output valid bit; the stack memory is not cleared.
// While out_stall is high a finished result holds in the output register and
// a next result waits in its final step until the register frees.
module region_page_allocator #(
  parameter int REGIONS      = 16,
  parameter int REGION_ORDER = 4,
  parameter int DOMAINS      = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rpa_pkg::in_word_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rpa_pkg::out_word_t out_data
);

  localparam int RIW   = (REGIONS > 1) ? $clog2(REGIONS) : 1;
  localparam int DIW   = (DOMAINS > 1) ? $clog2(DOMAINS) : 1;
  localparam int PW    = REGION_ORDER;
  localparam int CW    = REGION_ORDER + 1;
  localparam int PAGES = 1 << REGION_ORDER;
  localparam int AW    = RIW + PW;

  rpa_pkg::state_t state_r, state_nxt;
  rpa_pkg::in_word_t req_r;

  logic                      slot_valid_r [REGIONS];
  logic [DIW-1:0]            slot_domain_r [REGIONS];
  logic [rpa_pkg::AGE_W-1:0] slot_age_r [REGIONS];
  logic [CW-1:0]             bump_r [REGIONS];
  logic [CW-1:0]             fc_r [REGIONS];
  logic                      cache_valid_r [DOMAINS];
  logic [RIW-1:0]            cache_slot_r [DOMAINS];
  logic [rpa_pkg::AGE_W-1:0] age_r;

  // scan results
  logic [RIW-1:0]            idx_r;
  logic                      free_found_r;
  logic [RIW-1:0]            free_slot_r;
  logic                      open_found_r;
  logic [RIW-1:0]            best_r;
  logic [rpa_pkg::AGE_W-1:0] best_dist_r;

  // picked allocation
  logic           fb_r, pop_r, fresh_r;
  logic [RIW-1:0] sel_r;
  logic [PW-1:0]  bump_off_r;

  logic               out_valid_r;
  rpa_pkg::out_word_t out_data_r;
  rpa_pkg::out_word_t out_data_nxt;

  logic in_acc, out_free;
  logic [DIW-1:0] di;
  logic [RIW-1:0] fs;

  // scan step
  logic                      sc_mine, sc_full;
  logic [rpa_pkg::AGE_W-1:0] sc_dist;

  // pick step
  logic           pk_fb, pk_new, pk_pop;
  logic [RIW-1:0] pk_s;

  // free step
  logic fr_ok, fr_rel;

  logic [PW-1:0] pop_data;

  function automatic logic is_full(logic [CW-1:0] b, logic [CW-1:0] f);
    return (b >= CW'(PAGES)) && (f == '0);
  endfunction

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != rpa_pkg::S_IDLE);
  assign di       = DIW'(req_r.domain);
  assign fs       = RIW'(req_r.region);

  always_comb begin
    sc_full = is_full(bump_r[idx_r], fc_r[idx_r]);
    sc_mine = slot_valid_r[idx_r] && (slot_domain_r[idx_r] == di) && !sc_full;
    sc_dist = age_r - slot_age_r[idx_r];
  end

  always_comb begin
    pk_fb  = 1'b0;
    pk_new = 1'b0;
    pk_pop = 1'b0;
    pk_s   = best_r;
    if (int'(req_r.domain) >= DOMAINS) begin
      pk_fb = 1'b1;
    end else if (!open_found_r) begin
      if (!free_found_r) begin
        pk_fb = 1'b1;
      end else begin
        pk_new = 1'b1;
        pk_s   = free_slot_r;
      end
    end else begin
      if (cache_valid_r[di] &&
          !is_full(bump_r[cache_slot_r[di]], fc_r[cache_slot_r[di]])) begin
        pk_s = cache_slot_r[di];
      end
      pk_pop = (fc_r[pk_s] != '0);
    end
  end

  always_comb begin
    fr_ok  = (int'(req_r.region) < REGIONS) && slot_valid_r[fs] &&
             (fc_r[fs] < CW'(PAGES));
    fr_rel = (fc_r[fs] + CW'(1)) == CW'(PAGES);
  end

  rpa_stack_ram #(
    .DEPTH (REGIONS * PAGES),
    .AW    (AW),
    .DW    (PW)
  ) u_stack (
    .clk   (clk),
    .we    ((state_r == rpa_pkg::S_FREE) && out_free && fr_ok),
    .waddr ({fs, fc_r[fs][PW-1:0]}),
    .wdata (PW'(req_r.page_offset)),
    .re    ((state_r == rpa_pkg::S_PICK) && pk_pop),
    .raddr ({pk_s, fc_r[pk_s][PW-1:0] - PW'(1)}),
    .rdata (pop_data)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rpa_pkg::S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_data.func == rpa_pkg::FUNC_FREE) ? rpa_pkg::S_FREE
                                                           : rpa_pkg::S_SCAN;
        end
      end
      rpa_pkg::S_SCAN: begin
        if (idx_r == RIW'(REGIONS - 1)) begin
          state_nxt = rpa_pkg::S_PICK;
        end
      end
      rpa_pkg::S_PICK: state_nxt = rpa_pkg::S_FIN;
      rpa_pkg::S_FREE, rpa_pkg::S_FIN: begin
        if (out_free) begin
          state_nxt = rpa_pkg::S_IDLE;
        end
      end
      default: state_nxt = rpa_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rpa_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // request, scan and pick registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r        <= in_data;
      idx_r        <= '0;
      free_found_r <= 1'b0;
      open_found_r <= 1'b0;
    end else if (state_r == rpa_pkg::S_SCAN) begin
      idx_r <= idx_r + RIW'(1);
      if (!slot_valid_r[idx_r] && !free_found_r) begin
        free_found_r <= 1'b1;
        free_slot_r  <= idx_r;
      end
      if (sc_mine && (!open_found_r || sc_dist < best_dist_r)) begin
        open_found_r <= 1'b1;
        best_r       <= idx_r;
        best_dist_r  <= sc_dist;
      end
    end
    if (state_r == rpa_pkg::S_PICK) begin
      fb_r       <= pk_fb;
      pop_r      <= pk_pop;
      fresh_r    <= pk_new;
      sel_r      <= pk_s;
      bump_off_r <= pk_new ? '0 : bump_r[pk_s][PW-1:0];
    end
  end

  // slot owner and stamp, written when a slot opens
  always_ff @(posedge clk) begin
    if ((state_r == rpa_pkg::S_PICK) && pk_new) begin
      slot_domain_r[pk_s] <= di;
      slot_age_r[pk_s]    <= age_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REGIONS; i++) begin
        slot_valid_r[i] <= 1'b0;
        bump_r[i]       <= '0;
        fc_r[i]         <= '0;
      end
      for (int j = 0; j < DOMAINS; j++) begin
        cache_valid_r[j] <= 1'b0;
        cache_slot_r[j]  <= '0;
      end
      age_r <= '0;
    end else if ((state_r == rpa_pkg::S_PICK) && !pk_fb) begin
      cache_valid_r[di] <= 1'b1;
      cache_slot_r[di]  <= pk_s;
      if (pk_new) begin
        slot_valid_r[pk_s] <= 1'b1;
        bump_r[pk_s]       <= CW'(1);
        fc_r[pk_s]         <= '0;
        age_r              <= age_r + rpa_pkg::AGE_W'(1);
      end else if (pk_pop) begin
        fc_r[pk_s] <= fc_r[pk_s] - CW'(1);
      end else begin
        bump_r[pk_s] <= bump_r[pk_s] + CW'(1);
      end
    end else if ((state_r == rpa_pkg::S_FREE) && out_free && fr_ok) begin
      if (fr_rel) begin
        slot_valid_r[fs] <= 1'b0;
        bump_r[fs]       <= '0;
        fc_r[fs]         <= '0;
        if (cache_valid_r[slot_domain_r[fs]] &&
            cache_slot_r[slot_domain_r[fs]] == fs) begin
          cache_valid_r[slot_domain_r[fs]] <= 1'b0;
        end
      end else begin
        fc_r[fs] <= fc_r[fs] + CW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (((state_r == rpa_pkg::S_FREE) || (state_r == rpa_pkg::S_FIN)) &&
                 out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    out_data_nxt = '0;
    if (state_r == rpa_pkg::S_FREE) begin
      out_data_nxt.status = !fr_ok ? rpa_pkg::ST_REJECT :
                            fr_rel ? rpa_pkg::ST_RELEASED : rpa_pkg::ST_FREED;
    end else if (fb_r) begin
      out_data_nxt.status = rpa_pkg::ST_FALLBACK;
    end else begin
      out_data_nxt.status     = rpa_pkg::ST_ALLOC;
      out_data_nxt.out_region = 4'(sel_r);
      out_data_nxt.out_offset = pop_r ? 4'(pop_data) : 4'(bump_off_r);
      out_data_nxt.clear_page = req_r.zero_fill;
      out_data_nxt.new_region = fresh_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free &&
        ((state_r == rpa_pkg::S_FREE) || (state_r == rpa_pkg::S_FIN))) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### design/rpa_checker.sv
// port-level checks for the region page allocator, bound to the top level
module rpa_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input rpa_pkg::out_word_t out_data
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  // one request at a time: busy right after acceptance
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after acceptance");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // only allocations carry region, offset and flags
  a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != rpa_pkg::ST_ALLOC |->
      out_data.out_region == 4'd0 && out_data.out_offset == 4'd0 &&
      !out_data.clear_page && !out_data.new_region)
    else $error("non-allocation result carries page fields");

endmodule

bind region_page_allocator rpa_checker u_rpa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### tb/region_page_allocator_checker.sv
// checker for the region page allocator: watches both channels, predicts and compares
`timescale 1ns / 1ps

module region_page_allocator_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  rpa_pkg::in_word_t           in_data,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  rpa_pkg::out_word_t          out_data,
  output int                          fail_count,
  output int                          pending
);

  localparam int NSLOT = 16;
  localparam int NPAGE = 16;
  localparam int NDOM  = 4;

  logic        live [NSLOT];
  logic [1:0]  owner [NSLOT];
  logic [15:0] stamp [NSLOT];
  logic [15:0] stamp_ctr;
  logic [4:0]  bump [NSLOT];
  logic [4:0]  depth [NSLOT];
  logic [3:0]  stack [NSLOT*NPAGE];
  logic        cached [NDOM];
  logic [3:0]  cached_slot [NDOM];
  int          owned [NDOM];

  rpa_pkg::out_word_t result_q [$];

  function automatic bit is_full(int s);
    return bump[s] >= 5'(NPAGE) && depth[s] == 5'd0;
  endfunction

  function automatic rpa_pkg::out_word_t mk(logic [2:0] st, logic [3:0] r, logic [3:0] o,
                                            logic c, logic n);
    rpa_pkg::out_word_t w;
    w.status = st; w.out_region = r; w.out_offset = o; w.clear_page = c; w.new_region = n;
    return w;
  endfunction

  function automatic rpa_pkg::out_word_t mk_plain(logic [2:0] st);
    return mk(st, 4'd0, 4'd0, 1'b0, 1'b0);
  endfunction

  task automatic clear_model();
    for (int s = 0; s < NSLOT; s++) begin
      live[s] = 1'b0; owner[s] = '0; stamp[s] = '0; bump[s] = '0; depth[s] = '0;
    end
    for (int d = 0; d < NDOM; d++) begin
      cached[d] = 1'b0; cached_slot[d] = '0; owned[d] = 0;
    end
    stamp_ctr = '0;
  endtask

  function automatic rpa_pkg::out_word_t allocate_page(int d, logic zf);
    bit fresh;
    bit any_open;
    int pick;
    int s;
    logic [15:0] gap, best;
    logic [3:0] off;
    fresh = 0;
    any_open = 0;
    for (int i = 0; i < NSLOT; i++)
      if (live[i] && int'(owner[i]) == d && !is_full(i)) any_open = 1;
    if (owned[d] == 0 || !any_open) begin
      pick = -1;
      for (int i = NSLOT - 1; i >= 0; i--) if (!live[i]) pick = i;
      if (pick < 0) return mk_plain(rpa_pkg::ST_FALLBACK);
      live[pick] = 1'b1; owner[pick] = 2'(d); stamp[pick] = stamp_ctr;
      stamp_ctr = stamp_ctr + 16'd1;
      bump[pick] = '0; depth[pick] = '0; owned[d]++;
      cached[d] = 1'b1; cached_slot[d] = 4'(pick);
      fresh = 1;
    end
    if (!cached[d] || is_full(int'(cached_slot[d]))) begin
      pick = -1; best = '0;
      for (int i = 0; i < NSLOT; i++)
        if (live[i] && int'(owner[i]) == d && !is_full(i)) begin
          gap = stamp_ctr - stamp[i];
          if (pick < 0 || gap < best) begin pick = i; best = gap; end
        end
      if (pick < 0) return mk_plain(rpa_pkg::ST_FALLBACK);
      cached[d] = 1'b1; cached_slot[d] = 4'(pick);
    end
    s = int'(cached_slot[d]);
    if (depth[s] > 5'd0) begin
      depth[s] = depth[s] - 5'd1;
      off = stack[s*NPAGE + int'(depth[s])];
    end else if (bump[s] < 5'(NPAGE)) begin
      off = bump[s][3:0];
      bump[s] = bump[s] + 5'd1;
    end else return mk_plain(rpa_pkg::ST_FALLBACK);
    return mk(rpa_pkg::ST_ALLOC, s[3:0], off, zf, fresh);
  endfunction

  function automatic rpa_pkg::out_word_t free_page(int s, logic [3:0] off);
    int d;
    if (!live[s] || depth[s] >= 5'(NPAGE)) return mk_plain(rpa_pkg::ST_REJECT);
    stack[s*NPAGE + int'(depth[s])] = off;
    depth[s] = depth[s] + 5'd1;
    if (depth[s] < 5'(NPAGE)) return mk_plain(rpa_pkg::ST_FREED);
    d = int'(owner[s]);
    live[s] = 1'b0; bump[s] = '0; depth[s] = '0;
    if (cached[d] && int'(cached_slot[d]) == s) cached[d] = 1'b0;
    if (owned[d] > 0) owned[d]--;
    return mk_plain(rpa_pkg::ST_RELEASED);
  endfunction

  assign pending = result_q.size();

  always @(posedge clk) begin
    rpa_pkg::out_word_t want;
    if (!rst_n) begin
      clear_model();
      result_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result word %h", out_data);
        end else begin
          want = result_q.pop_front();
          if (want.status !== out_data.status || want.out_region !== out_data.out_region ||
              want.out_offset !== out_data.out_offset ||
              want.clear_page !== out_data.clear_page ||
              want.new_region !== out_data.new_region) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"mismatch: expected st=%0d reg=%0d off=%0d clr=%0d new=%0d,",
                        " got st=%0d reg=%0d off=%0d clr=%0d new=%0d"},
                       want.status, want.out_region, want.out_offset, want.clear_page,
                       want.new_region, out_data.status, out_data.out_region,
                       out_data.out_offset, out_data.clear_page, out_data.new_region);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_data.func == rpa_pkg::FUNC_ALLOC)
          result_q.push_back(allocate_page(int'(in_data.domain), in_data.zero_fill));
        else
          result_q.push_back(free_page(int'(in_data.region), in_data.page_offset));
      end
    end
  end
endmodule

### tb/region_page_allocator_tb.sv
// testbench top for the region page allocator: stimulus, reset and verdict
`timescale 1ns / 1ps

module region_page_allocator_tb;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_stall;
  rpa_pkg::in_word_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 0;
  rpa_pkg::out_word_t out_data;
  int                 fail_count;
  int                 pending;

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_off = 0;

  // live pages the stimulus knows about, for well-formed frees
  logic [3:0] held_reg [$];
  logic [3:0] held_off [$];

  always #5 clk = ~clk;

  region_page_allocator u_dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  region_page_allocator_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data), .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // track allocated pages from the result side
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall && out_data.status == rpa_pkg::ST_ALLOC) begin
      held_reg.push_back(out_data.out_region);
      held_off.push_back(out_data.out_offset);
    end
  end

  // valid stays up after acceptance until the next idle cycle or drain
  task automatic send_word(rpa_pkg::in_word_t w);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic rpa_pkg::in_word_t alloc_word(logic [1:0] d, logic zf);
    rpa_pkg::in_word_t w;
    w = $bits(rpa_pkg::in_word_t)'($urandom);
    w.func = rpa_pkg::FUNC_ALLOC; w.domain = d; w.zero_fill = zf;
    return w;
  endfunction

  function automatic rpa_pkg::in_word_t free_word(logic [3:0] r, logic [3:0] o);
    rpa_pkg::in_word_t w;
    w = $bits(rpa_pkg::in_word_t)'($urandom);
    w.func = rpa_pkg::FUNC_FREE; w.region = r; w.page_offset = o;
    return w;
  endfunction

  task automatic send_random();
    int k;
    int pick;
    rpa_pkg::in_word_t w;
    k = $urandom_range(99);
    if (k < 50) send_word(alloc_word(2'($urandom), 1'($urandom)));
    else if (k < 88 && held_reg.size() > 0) begin
      pick = $urandom_range(held_reg.size() - 1);
      w = free_word(held_reg[pick], held_off[pick]);
      held_reg.delete(pick);
      held_off.delete(pick);
      send_word(w);
    end else send_word(free_word(4'($urandom), 4'($urandom)));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: free to empty slot, fill one region, release it, extremes
    send_word(free_word(4'd15, 4'd15));
    send_word(free_word(4'd0, 4'd0));
    for (int i = 0; i < 17; i++) send_word(alloc_word(2'd3, i[0]));
    send_word(alloc_word(2'd0, 1'b1));
    drain();
    for (int i = 0; i < 16; i++) send_word(free_word(4'd0, i[3:0]));
    held_reg.delete(); held_off.delete();
    drain();
    // exhaust slots to reach fallback
    for (int i = 0; i < 17 * 16 + 2; i++) send_word(alloc_word(i[1:0], 1'($urandom)));
    drain();
    // long receiver hold-off while sender keeps offering
    hold_off = 1;
    fork
      begin repeat (300) @(posedge clk); hold_off = 0; end
      for (int i = 0; i < 40; i++) send_random();
    join
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      for (int i = 0; i < 300; i++) send_random();
      drain();
    end
    send_idle_pct = 0; recv_stall_pct = 0;
    for (int i = 0; i < 350; i++) send_random();
    drain();
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
